[hw/rtl/ctrr_pkg.sv]
// ----------------------------------------------------------------------------
// ctrr_pkg
// shared types and constants of the cooperative thread round-robin scheduler
// ----------------------------------------------------------------------------
package ctrr_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W        = 4;
    localparam int CNT_W       = 5;
    localparam int QIDX_W      = $clog2(MAX_THREADS);
    localparam int ACT_W       = 3;
    localparam int OUTC_W      = 2;

    typedef enum logic [1:0] {
        ST_DEAD   = 2'd0,
        ST_PAUSED = 2'd1,
        ST_READY  = 2'd2
    } thr_status_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE   = 3'd0,
        ACT_KILL     = 3'd1,
        ACT_PAUSE    = 3'd2,
        ACT_WAKE     = 3'd3,
        ACT_SCHEDULE = 3'd4
    } action_t;

    typedef enum logic [OUTC_W-1:0] {
        OUTC_OK       = 2'd0,
        OUTC_FULL     = 2'd1,
        OUTC_DEADLOCK = 2'd2,
        OUTC_FINISHED = 2'd3
    } outcome_t;

    typedef struct packed {
        logic accept;
        logic walk;
        logic copy;
    } dp_cmd_t;

    typedef struct packed {
        logic sched_walk;
        logic walk_done;
        logic found;
        logic copy_done;
        logic out_valid;
    } dp_stat_t;

endpackage

[hw/rtl/ctrr_ctrl.sv]
// ----------------------------------------------------------------------------
// ctrr_ctrl
// sequencer: idle, queue prune walk and rotation copy
// ----------------------------------------------------------------------------
module ctrr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              m_ready,
    input  ctrr_pkg::dp_stat_t stat,
    output ctrr_pkg::dp_cmd_t  cmd
);
    import ctrr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_COPY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready    = (state_reg == S_IDLE) && (!stat.out_valid || m_ready);
    assign cmd.accept = s_valid && s_ready;
    assign cmd.walk   = (state_reg == S_WALK);
    assign cmd.copy   = (state_reg == S_COPY);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept && stat.sched_walk) begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    state_next = stat.found ? S_COPY : S_IDLE;
                end
            end
            S_COPY: begin
                if (stat.copy_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/ctrr_datapath.sv]
// ----------------------------------------------------------------------------
// ctrr_datapath
// thread status table, circular run queue, counters and result register
// ----------------------------------------------------------------------------
module ctrr_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ctrr_pkg::ACT_W-1:0]   s_action,
    input  logic [ctrr_pkg::ID_W-1:0]    s_thread_id,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [ctrr_pkg::OUTC_W-1:0]  m_outcome,
    output logic [ctrr_pkg::ID_W-1:0]    m_chosen_id,
    output logic [ctrr_pkg::CNT_W-1:0]   m_alive_count,
    input  ctrr_pkg::dp_cmd_t            cmd,
    output ctrr_pkg::dp_stat_t           stat
);
    import ctrr_pkg::*;

    thr_status_t             status_reg [MAX_THREADS];
    logic [ID_W-1:0]         queue_reg  [MAX_THREADS];
    logic [QIDX_W-1:0]       head_reg,    head_next;
    logic [CNT_W-1:0]        len_reg,     len_next;
    logic [CNT_W-1:0]        created_reg, created_next;
    logic [CNT_W-1:0]        killed_reg,  killed_next;
    logic [CNT_W-1:0]        r_reg,       r_next;
    logic [CNT_W-1:0]        w_reg,       w_next;
    logic [QIDX_W-1:0]       k_reg,       k_next;
    logic [QIDX_W-1:0]       p_reg,       p_next;
    logic                    found_reg,   found_next;
    logic [ID_W-1:0]         chosen_reg,  chosen_next;
    logic                    ov_reg,      ov_next;
    logic [OUTC_W-1:0]       oc_reg,      oc_next;
    logic [ID_W-1:0]         oid_reg,     oid_next;

    logic [QIDX_W-1:0]       q_ra;
    logic [ID_W-1:0]         q_rd;
    logic                    q_we;
    logic [QIDX_W-1:0]       q_wa;
    logic [ID_W-1:0]         q_wd;
    logic [ID_W-1:0]         st_addr;
    thr_status_t             st_rd;
    logic                    st_we;
    logic [ID_W-1:0]         st_wa;
    thr_status_t             st_wd;
    logic                    main_dead;
    logic                    live;
    logic                    walk_done;
    logic                    copy_done;
    logic                    out_load;
    logic [OUTC_W-1:0]       out_code;
    logic [ID_W-1:0]         out_id;

    assign main_dead = (status_reg[0] == ST_DEAD);
    assign walk_done = (r_reg == len_reg);
    assign copy_done = (k_reg == p_reg);

    assign q_ra    = cmd.walk ? head_reg + r_reg[QIDX_W-1:0] : head_reg + k_reg;
    assign q_rd    = queue_reg[q_ra];
    assign st_addr = cmd.walk ? q_rd : s_thread_id;
    assign st_rd   = status_reg[st_addr];
    assign live    = ({1'b0, s_thread_id} < CNT_W'(MAX_THREADS)) && (st_rd != ST_DEAD);

    assign stat.sched_walk = (s_action == ACT_SCHEDULE) && !main_dead;
    assign stat.walk_done  = walk_done;
    assign stat.found      = found_reg;
    assign stat.copy_done  = copy_done;
    assign stat.out_valid  = ov_reg;

    always_comb begin
        head_next    = head_reg;
        len_next     = len_reg;
        created_next = created_reg;
        killed_next  = killed_reg;
        r_next       = r_reg;
        w_next       = w_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        found_next   = found_reg;
        chosen_next  = chosen_reg;
        q_we         = 1'b0;
        q_wa         = head_reg + len_reg[QIDX_W-1:0];
        q_wd         = created_reg[ID_W-1:0];
        st_we        = 1'b0;
        st_wa        = s_thread_id;
        st_wd        = ST_READY;
        out_load     = 1'b0;
        out_code     = OUTC_OK;
        out_id       = '0;

        if (cmd.accept) begin
            out_load = 1'b1;
            case (s_action)
                ACT_CREATE: begin
                    if (created_reg >= CNT_W'(MAX_THREADS)) begin
                        out_code = OUTC_FULL;
                    end else begin
                        st_we        = 1'b1;
                        st_wa        = created_reg[ID_W-1:0];
                        st_wd        = ST_READY;
                        if (len_reg < CNT_W'(MAX_THREADS)) begin
                            q_we     = 1'b1;
                            len_next = len_reg + CNT_W'(1);
                        end
                        created_next = created_reg + CNT_W'(1);
                        out_id       = created_reg[ID_W-1:0];
                    end
                end
                ACT_KILL: begin
                    if (live) begin
                        st_we       = 1'b1;
                        st_wd       = ST_DEAD;
                        killed_next = killed_reg + CNT_W'(1);
                    end
                end
                ACT_PAUSE: begin
                    st_we = live;
                    st_wd = ST_PAUSED;
                end
                ACT_WAKE: begin
                    st_we = live;
                    st_wd = ST_READY;
                end
                ACT_SCHEDULE: begin
                    if (main_dead) begin
                        out_code = OUTC_FINISHED;
                    end else begin
                        out_load   = 1'b0;
                        r_next     = '0;
                        w_next     = '0;
                        found_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end else if (cmd.walk) begin
            if (walk_done) begin
                len_next = w_reg;
                k_next   = '0;
                if (!found_reg) begin
                    out_load = 1'b1;
                    out_code = OUTC_DEADLOCK;
                end
            end else begin
                r_next = r_reg + CNT_W'(1);
                if (st_rd != ST_DEAD) begin
                    q_we   = 1'b1;
                    q_wa   = head_reg + w_reg[QIDX_W-1:0];
                    q_wd   = q_rd;
                    w_next = w_reg + CNT_W'(1);
                    if (st_rd == ST_READY && !found_reg) begin
                        found_next  = 1'b1;
                        p_next      = w_reg[QIDX_W-1:0];
                        chosen_next = q_rd;
                    end
                end
            end
        end else if (cmd.copy) begin
            // skipped entries and the chosen one go past the tail
            q_we   = 1'b1;
            q_wa   = head_reg + len_reg[QIDX_W-1:0] + k_reg;
            q_wd   = q_rd;
            k_next = k_reg + QIDX_W'(1);
            if (copy_done) begin
                head_next = head_reg + p_reg + QIDX_W'(1);
                out_load  = 1'b1;
                out_code  = OUTC_OK;
                out_id    = chosen_reg;
            end
        end

        ov_next  = out_load ? 1'b1 : (m_ready ? 1'b0 : ov_reg);
        oc_next  = out_load ? out_code : oc_reg;
        oid_next = out_load ? out_id : oid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                status_reg[i] <= ST_DEAD;
            end
            head_reg    <= '0;
            len_reg     <= '0;
            created_reg <= '0;
            killed_reg  <= '0;
            r_reg       <= '0;
            w_reg       <= '0;
            k_reg       <= '0;
            p_reg       <= '0;
            found_reg   <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            if (st_we) begin
                status_reg[st_wa] <= st_wd;
            end
            head_reg    <= head_next;
            len_reg     <= len_next;
            created_reg <= created_next;
            killed_reg  <= killed_next;
            r_reg       <= r_next;
            w_reg       <= w_next;
            k_reg       <= k_next;
            p_reg       <= p_next;
            found_reg   <= found_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_reg[q_wa] <= q_wd;
        end
        chosen_reg <= chosen_next;
        oc_reg     <= oc_next;
        oid_reg    <= oid_next;
    end

    assign m_valid       = ov_reg;
    assign m_outcome     = oc_reg;
    assign m_chosen_id   = oid_reg;
    assign m_alive_count = created_reg - killed_reg;

endmodule

[hw/rtl/coop_thread_round_robin_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// coop_thread_round_robin_scheduler_unit
// round-robin scheduler for cooperative threads
// ----------------------------------------------------------------------------
// Input channel s_*: one beat carries an action (create, kill, pause, wake,
// schedule) and a target thread id. Result channel m_*: one beat per input
// beat, carrying outcome, chosen id and the live thread count.
// Create, kill, pause, wake, unknown codes and a finished schedule give their
// result in the cycle after acceptance. A schedule that runs walks the run
// queue once to drop dead threads and, when a ready thread is found, copies
// the skipped entries and the chosen one to the tail; with no ready thread
// (empty queue, deadlock) it ends after the walk.
// One item is in flight at a time. The next beat is taken in the cycle the
// previous result is taken, or at once while the result register is empty.
// A stalled receiver holds the result register and blocks new input.
// Reset marks all threads dead and empties the queue and counters.
// ----------------------------------------------------------------------------
module coop_thread_round_robin_scheduler_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ctrr_pkg::ACT_W-1:0]   s_action,
    input  logic [ctrr_pkg::ID_W-1:0]    s_thread_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ctrr_pkg::OUTC_W-1:0]  m_outcome,
    output logic [ctrr_pkg::ID_W-1:0]    m_chosen_id,
    output logic [ctrr_pkg::CNT_W-1:0]   m_alive_count
);
    import ctrr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ctrr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ctrr_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_action),
        .s_thread_id   (s_thread_id),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_outcome     (m_outcome),
        .m_chosen_id   (m_chosen_id),
        .m_alive_count (m_alive_count),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[sim/tb_coop_thread_round_robin_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// tb_coop_thread_round_robin_scheduler_unit
// self-checking bench for the cooperative thread round-robin scheduler
// ----------------------------------------------------------------------------
// Every beat sent on the s_ channel is run through a behavioural copy of the
// thread table and run queue kept inside the bench. The expected outcome,
// chosen id and live count go onto a queue, and each beat taken from the m_
// channel is compared field by field with the oldest entry. Directed tests
// cover the empty scheduler, dead targets, unknown codes, a single thread,
// deadlock and queue rotation, then a long random mix, a full thread table
// and the main thread exiting. Both channels idle in random bursts except
// in quiet stretches and at the end of the run.
// ----------------------------------------------------------------------------
module tb_coop_thread_round_robin_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ctrr_pkg::*;

    typedef struct {
        outcome_t         outcome;
        logic [ID_W-1:0]  chosen_id;
        logic [CNT_W-1:0] alive_count;
    } sched_result_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [ACT_W-1:0]   s_action      = '0;
    logic [ID_W-1:0]    s_thread_id   = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [OUTC_W-1:0]  m_outcome;
    logic [ID_W-1:0]    m_chosen_id;
    logic [CNT_W-1:0]   m_alive_count;

    thr_status_t        thr_state [MAX_THREADS];
    logic [ID_W-1:0]    run_q [MAX_THREADS];
    int                 run_len;
    int                 n_created;
    int                 n_killed;

    sched_result_t      awaited_results [$];
    int                 fail_count = 0;
    bit                 calm = 1'b0;

    coop_thread_round_robin_scheduler_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_thread_id   (s_thread_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_outcome     (m_outcome),
        .m_chosen_id   (m_chosen_id),
        .m_alive_count (m_alive_count)
    );

    always #4 aclk = ~aclk;

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void clear_thread_table();
        int i;
        for (i = 0; i < MAX_THREADS; i++) begin
            thr_state[i] = ST_DEAD;
            run_q[i]     = '0;
        end
        run_len   = 0;
        n_created = 0;
        n_killed  = 0;
    endfunction

    function automatic sched_result_t compute_sched_result(logic [ACT_W-1:0] act,
                                                           logic [ID_W-1:0] tid);
        sched_result_t   r;
        logic [ID_W-1:0] rotated [MAX_THREADS];
        int              i;
        int              w;
        int              p;
        logic            live;
        r.outcome   = OUTC_OK;
        r.chosen_id = '0;
        live        = (thr_state[tid] != ST_DEAD);
        case (act)
            ACT_CREATE: begin
                if (n_created >= MAX_THREADS) begin
                    r.outcome = OUTC_FULL;
                end else begin
                    thr_state[n_created] = ST_READY;
                    if (run_len < MAX_THREADS) begin
                        run_q[run_len] = ID_W'(n_created);
                        run_len++;
                    end
                    r.chosen_id = ID_W'(n_created);
                    n_created++;
                end
            end
            ACT_KILL: begin
                if (live) begin
                    thr_state[tid] = ST_DEAD;
                    n_killed++;
                end
            end
            ACT_PAUSE: begin
                if (live) thr_state[tid] = ST_PAUSED;
            end
            ACT_WAKE: begin
                if (live) thr_state[tid] = ST_READY;
            end
            ACT_SCHEDULE: begin
                if (thr_state[0] == ST_DEAD) begin
                    r.outcome = OUTC_FINISHED;
                end else begin
                    // drop dead threads, keeping order
                    w = 0;
                    for (i = 0; i < run_len; i++) begin
                        if (thr_state[run_q[i]] != ST_DEAD) begin
                            run_q[w] = run_q[i];
                            w++;
                        end
                    end
                    run_len = w;
                    p = -1;
                    for (i = 0; i < run_len; i++) begin
                        if (p < 0 && thr_state[run_q[i]] == ST_READY) p = i;
                    end
                    if (p < 0) begin
                        r.outcome = OUTC_DEADLOCK;
                    end else begin
                        // skipped threads then the chosen one go to the tail
                        for (i = 0; i < run_len; i++) begin
                            rotated[i] = run_q[(p + 1 + i) % run_len];
                        end
                        for (i = 0; i < run_len; i++) run_q[i] = rotated[i];
                        r.chosen_id = rotated[run_len - 1];
                    end
                end
            end
            default: ;
        endcase
        r.alive_count = CNT_W'(n_created - n_killed);
        return r;
    endfunction

    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] tid);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_thread_id <= tid;
        awaited_results.push_back(compute_sched_result(act, tid));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // receiver stalls
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string field, input int exp_v, input int got_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    endtask

    // result beat checker
    always @(posedge aclk) begin
        sched_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected beat outcome", -1, m_outcome);
            end else begin
                e = awaited_results.pop_front();
                if (m_outcome !== e.outcome)
                    report_mismatch("outcome", e.outcome, m_outcome);
                if (m_chosen_id !== e.chosen_id)
                    report_mismatch("chosen_id", e.chosen_id, m_chosen_id);
                if (m_alive_count !== e.alive_count)
                    report_mismatch("alive_count", e.alive_count, m_alive_count);
            end
        end
    end

    task automatic test_empty_scheduler();
        send_beat(ACT_SCHEDULE, 4'd0);
        send_beat(3'd5, 4'd15);
        send_beat(3'd6, 4'd10);
        send_beat(3'd7, 4'd5);
    endtask

    task automatic test_dead_targets();
        send_beat(ACT_KILL, 4'd3);
        send_beat(ACT_PAUSE, 4'd15);
        send_beat(ACT_WAKE, 4'd0);
        send_beat(ACT_KILL, 4'd0);
    endtask

    task automatic test_single_thread();
        send_beat(ACT_CREATE, 4'd9);
        send_beat(ACT_SCHEDULE, 4'd0);
        send_beat(ACT_SCHEDULE, 4'd7);
    endtask

    task automatic test_deadlock();
        send_beat(ACT_PAUSE, 4'd0);
        send_beat(ACT_SCHEDULE, 4'd0);
        send_beat(ACT_WAKE, 4'd0);
        send_beat(ACT_SCHEDULE, 4'd0);
    endtask

    task automatic test_rotation();
        repeat (3) send_beat(ACT_CREATE, 4'd0);
        send_beat(ACT_PAUSE, 4'd1);
        send_beat(ACT_PAUSE, 4'd0);
        send_beat(ACT_SCHEDULE, 4'd0);
        send_beat(ACT_KILL, 4'd3);
        send_beat(ACT_SCHEDULE, 4'd0);
        send_beat(ACT_WAKE, 4'd0);
        send_beat(ACT_WAKE, 4'd1);
    endtask

    task automatic test_random_mix(input int n_beats);
        int               i;
        int               pick;
        logic [ACT_W-1:0] act;
        logic [ID_W-1:0]  tid;
        for (i = 0; i < n_beats; i++) begin
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            if (i >= n_beats - 100) calm = 1'b1;
            pick = $urandom_range(0, 99);
            tid  = ID_W'($urandom_range(0, 15));
            if (pick < 6) begin
                act = ACT_CREATE;
            end else if (pick < 9) begin
                // keep the main thread alive until the exit test
                act = ACT_KILL;
                tid = ID_W'($urandom_range(1, 15));
            end else if (pick < 35) begin
                act = ACT_PAUSE;
            end else if (pick < 65) begin
                act = ACT_WAKE;
            end else if (pick < 95) begin
                act = ACT_SCHEDULE;
            end else begin
                act = ACT_W'($urandom_range(5, 7));
            end
            send_beat(act, tid);
        end
    endtask

    task automatic test_table_full();
        while (n_created < MAX_THREADS) send_beat(ACT_CREATE, 4'd0);
        send_beat(ACT_CREATE, 4'd15);
        send_beat(ACT_CREATE, 4'd0);
    endtask

    task automatic test_main_thread_exit();
        send_beat(ACT_KILL, 4'd0);
        send_beat(ACT_SCHEDULE, 4'd0);
        send_beat(ACT_WAKE, 4'd0);
        send_beat(ACT_SCHEDULE, 4'd0);
    endtask

    initial begin
        clear_thread_table();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_scheduler();
        test_dead_targets();
        test_single_thread();
        test_deadlock();
        test_rotation();
        test_random_mix(575);
        calm = 1'b1;
        test_table_full();
        test_main_thread_exit();

        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
